/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top level of the LIN diagnostic reassembler.
// No dependencies; the macros compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks a property at every rising clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Checks that a condition implies a consequence in the next clock cycle.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CHK_ALWAYS(lbl, clk, rst, prop)
`define CHK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/ldmr_pkg.sv */
// Types and constants of the LIN diagnostic message reassembler.
// No dependencies; used by every module of the block.
package ldmr_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PROGRESS = 3'd0,
    ST_DONE     = 3'd1,
    ST_BUS      = 3'd2,
    ST_NAD      = 3'd3,
    ST_PCI      = 3'd4,
    ST_UNEXP    = 3'd5,
    ST_CNT      = 3'd6,
    ST_LEN      = 3'd7
  } status_t;

  // Node address that accepts any responder, also the reset value.
  localparam logic [7:0] NAD_ANY = 8'h7F;

  // Frame type codes in the upper nibble of the protocol control byte.
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  // Largest data byte counts of the frame types.
  localparam logic [3:0]  SF_BYTES   = 4'd6;
  localparam logic [2:0]  FF_BYTES   = 3'd5;
  localparam logic [2:0]  CF_BYTES   = 3'd6;

  // One received frame; data[0] is the node address byte.
  typedef struct packed {
    logic            rx_ok;
    logic [7:0][7:0] data;
  } frame_t;

  // Message state carried from frame to frame.
  typedef struct packed {
    logic        in_multi;
    logic [7:0]  active_nad;
    logic [3:0]  expected_counter;
    logic [11:0] bytes_received;
    logic [11:0] total_length;
  } msg_state_t;

  // One result.
  typedef struct packed {
    status_t         status;
    logic [5:0][7:0] payload;
    logic [2:0]      count;
    logic [11:0]     offset;
    logic [11:0]     mlen;
    logic [7:0]      nad;
  } result_t;

endpackage

/* hw/rtl/ldmr_input_reg.sv */
// Input register stage of the reassembler: holds one frame request.
// Depends on ldmr_pkg.
module ldmr_input_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ldmr_pkg::frame_t frame_in,
  input  logic            advance,
  output logic            q_valid,
  output ldmr_pkg::frame_t frame_q
);
  import ldmr_pkg::*;

  logic accept;

  // The register is free when empty or when its frame moves on this cycle.
  assign in_stall = q_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Valid flag of the held request.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  // Frame payload, loaded on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      frame_q <= frame_in;
    end
  end

endmodule

/* hw/rtl/ldmr_frame_decode.sv */
// Combinational decode of one frame against the message state.
// Depends on ldmr_pkg; produces the result and the next message state.
module ldmr_frame_decode (
  input  ldmr_pkg::frame_t     frame,
  input  ldmr_pkg::msg_state_t st,
  input  logic [7:0]           expected_nad,
  output ldmr_pkg::result_t    res,
  output ldmr_pkg::msg_state_t st_next
);
  import ldmr_pkg::*;

  logic [3:0]      pci_type;
  logic [3:0]      pci_low;
  logic [7:0]      nad;
  logic [11:0]     ff_len;
  logic [3:0]      next_cnt;
  logic [11:0]     left;
  logic [11:0]     br_sum;
  logic [2:0]      n;
  logic            src_ff;
  logic            finish;
  logic [5:0][7:0] sf_bytes;
  logic [5:0][7:0] ff_bytes;

  assign pci_type = frame.data[1][7:4];
  assign pci_low  = frame.data[1][3:0];
  assign ff_len   = {pci_low, frame.data[2]};
  assign next_cnt = st.expected_counter + 4'd1;
  assign left     = (st.total_length > st.bytes_received) ?
                    (st.total_length - st.bytes_received) : 12'd0;
  assign sf_bytes = frame.data[7:2];
  assign ff_bytes = {8'h00, frame.data[7:3]};

  // Frame classification and state update.
  always_comb begin
    nad          = st.in_multi ? st.active_nad : expected_nad;
    res.status   = ST_PROGRESS;
    res.offset   = st.bytes_received;
    res.mlen     = st.in_multi ? st.total_length : 12'd0;
    n            = 3'd0;
    br_sum       = st.bytes_received;
    src_ff       = 1'b0;
    finish       = 1'b1;
    st_next      = st;
    if (!frame.rx_ok) begin
      res.status = ST_BUS;
    end else begin
      if (!st.in_multi && nad == NAD_ANY) begin
        nad = frame.data[0];
      end
      if (frame.data[0] != nad) begin
        res.status = ST_NAD;
      end else begin
        unique case (pci_type)
          PCI_SF: begin
            if (st.in_multi) begin
              res.status = ST_UNEXP;
            end else if (pci_low == 4'd0 || pci_low > SF_BYTES) begin
              res.status = ST_LEN;
            end else begin
              res.status = ST_DONE;
              n          = pci_low[2:0];
              res.offset = 12'd0;
              res.mlen   = {8'd0, pci_low};
            end
          end
          PCI_FF: begin
            if (st.in_multi) begin
              res.status = ST_UNEXP;
            end else if (ff_len == 12'd0) begin
              res.status = ST_LEN;
            end else begin
              n          = (ff_len < 12'(FF_BYTES)) ? ff_len[2:0] : FF_BYTES;
              src_ff     = 1'b1;
              res.offset = 12'd0;
              res.mlen   = ff_len;
              if (ff_len <= 12'(FF_BYTES)) begin
                res.status = ST_DONE;
              end else begin
                finish                   = 1'b0;
                st_next.in_multi         = 1'b1;
                st_next.active_nad       = nad;
                st_next.expected_counter = 4'd0;
                st_next.bytes_received   = 12'(FF_BYTES);
                st_next.total_length     = ff_len;
              end
            end
          end
          PCI_CF: begin
            if (!st.in_multi) begin
              res.status = ST_UNEXP;
            end else if (pci_low != next_cnt) begin
              res.status = ST_CNT;
            end else begin
              n                        = (left < 12'(CF_BYTES)) ? left[2:0] : CF_BYTES;
              br_sum                   = st.bytes_received + 12'(n);
              st_next.bytes_received   = br_sum;
              st_next.expected_counter = next_cnt;
              if (br_sum >= st.total_length) begin
                res.status = ST_DONE;
              end else begin
                finish = 1'b0;
              end
            end
          end
          default: begin
            res.status = ST_PCI;
          end
        endcase
      end
    end
    // A finished or failed message returns to idle.
    if (finish) begin
      st_next.in_multi         = 1'b0;
      st_next.active_nad       = expected_nad;
      st_next.expected_counter = 4'd0;
      st_next.bytes_received   = 12'd0;
      st_next.total_length     = 12'd0;
    end
    res.count = n;
    res.nad   = nad;
    // Payload lanes: bytes from the selected source up to the count, zero beyond.
    for (int i = 0; i < 6; i++) begin
      if (3'(i) < n) begin
        res.payload[i] = src_ff ? ff_bytes[i] : sf_bytes[i];
      end else begin
        res.payload[i] = 8'h00;
      end
    end
  end

endmodule

/* hw/rtl/lin_diag_message_reassembler_top.sv */
// LIN diagnostic message reassembler, top level: message state and result register.
// Depends on ldmr_pkg, ldmr_input_reg, ldmr_frame_decode and assert_macros.svh.
//
// Takes one received LIN diagnostic response frame per request and returns one
// result per frame: the status, up to six payload bytes with their count and
// message offset, the message length and the node address in use. A frame goes
// through an input register, one pass of decode logic that also updates the
// message state, and a result register from which the result is presented; one
// frame per clock is sustained while the result side
// does not stall. The node address register may be written with cfg_write_en
// while no frame is in flight; 127 accepts any responder and locks onto the
// address of the frame that opens a message.
`include "assert_macros.svh"
module lin_diag_message_reassembler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [7:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        rx_ok,
  input  logic [7:0]  frame_byte0,
  input  logic [7:0]  frame_byte1,
  input  logic [7:0]  frame_byte2,
  input  logic [7:0]  frame_byte3,
  input  logic [7:0]  frame_byte4,
  input  logic [7:0]  frame_byte5,
  input  logic [7:0]  frame_byte6,
  input  logic [7:0]  frame_byte7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  payload0,
  output logic [7:0]  payload1,
  output logic [7:0]  payload2,
  output logic [7:0]  payload3,
  output logic [7:0]  payload4,
  output logic [7:0]  payload5,
  output logic [2:0]  payload_count,
  output logic [11:0] byte_offset,
  output logic [11:0] message_length,
  output logic [7:0]  responder_nad
);
  import ldmr_pkg::*;

  frame_t     frame_in;
  frame_t     frame_q;
  logic       q_valid;
  logic       advance;
  logic [7:0] expected_nad;
  msg_state_t st;
  msg_state_t st_next;
  result_t    res;
  result_t    res_q;

  assign frame_in.rx_ok = rx_ok;
  assign frame_in.data  = {frame_byte7, frame_byte6, frame_byte5, frame_byte4,
                           frame_byte3, frame_byte2, frame_byte1, frame_byte0};

  // A held frame moves on when the result register is empty or being drained.
  assign advance = q_valid && (!out_valid || !out_stall);

  ldmr_input_reg u_input_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .frame_in (frame_in),
    .advance  (advance),
    .q_valid  (q_valid),
    .frame_q  (frame_q)
  );

  ldmr_frame_decode u_frame_decode (
    .frame        (frame_q),
    .st           (st),
    .expected_nad (expected_nad),
    .res          (res),
    .st_next      (st_next)
  );

  // Node address register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_nad <= NAD_ANY;
    end else if (cfg_write_en) begin
      expected_nad <= cfg_write_data;
    end
  end

  // Message state; an idle message takes a new node address unless a frame advances in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.in_multi         <= 1'b0;
      st.active_nad       <= NAD_ANY;
      st.expected_counter <= 4'd0;
      st.bytes_received   <= 12'd0;
      st.total_length     <= 12'd0;
    end else if (advance) begin
      st <= st_next;
    end else if (cfg_write_en && !st.in_multi) begin
      st.active_nad <= cfg_write_data;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign status         = res_q.status;
  assign payload0       = res_q.payload[0];
  assign payload1       = res_q.payload[1];
  assign payload2       = res_q.payload[2];
  assign payload3       = res_q.payload[3];
  assign payload4       = res_q.payload[4];
  assign payload5       = res_q.payload[5];
  assign payload_count  = res_q.count;
  assign byte_offset    = res_q.offset;
  assign message_length = res_q.mlen;
  assign responder_nad  = res_q.nad;

  // Completion or any error leaves no message open.
  `CHK_NEXT(a_end_closes, clk, rst, advance && res.status != ST_PROGRESS, !st.in_multi)
  // A frame in progress always leaves a multi-frame message open.
  `CHK_NEXT(a_progress_opens, clk, rst, advance && res.status == ST_PROGRESS, st.in_multi)
  // An open message has bytes still to come.
  `CHK_ALWAYS(a_bytes_left, clk, rst, !st.in_multi || st.bytes_received < st.total_length)
  // A delivered result never claims more than six payload bytes.
  `CHK_ALWAYS(a_count_range, clk, rst, !out_valid || payload_count <= CF_BYTES)

endmodule
